// ===== design/ilir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and constants for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
package ilir_pkg;

   // default geometry
   localparam int unsigned CAPACITY_DEF  = 64;
   localparam int unsigned WORD_BITS_DEF = 32;

   // fixed port widths
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned POS_W    = 7;
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 7;

   // operation codes
   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_GET    = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_REMOVE = 2'd3
   } action_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // broadcast command from the control logic to every cell
   typedef struct packed {
      logic             ins_shift;  // entries above position move up
      logic             rem_shift;  // entries at and above position move down
      logic             write;      // entry at position takes the data word
      logic [POS_W-1:0] position;
   } cell_cmd_type;

endpackage : ilir_pkg
`default_nettype wire

// ===== design/indexed_list_insert_remove_top.sv =====
// An input transfer's result is registered in the output register.
// Throughput: one operation per cycle unless the result stalls; the output
// register frees the input as it is taken, and all cells shift, load or hold
// together in the accepting cycle. Reset clears the entry count and the output
// valid; entry contents are undefined until written and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_top
// Ordered word list with insert, get, update and remove, built as a row
// of cells that each hold one entry.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_top #(
   parameter int unsigned CAPACITY  = ilir_pkg::CAPACITY_DEF,
   parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ilir_pkg::ACTION_W-1:0] req_action,
   input  wire logic [ilir_pkg::POS_W-1:0]    req_position,
   input  wire logic [ilir_pkg::DATA_W-1:0]   req_data_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [ilir_pkg::DATA_W-1:0]   rsp_read_word,
   output logic      [ilir_pkg::STATUS_W-1:0] rsp_status,
   output logic      [ilir_pkg::COUNT_W-1:0]  rsp_count
);
   import ilir_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // control and result registers
   logic                 rsp_valid_ff,  rsp_valid_in;
   logic [DATA_W-1:0]    read_word_ff,  read_word_in;
   status_type           status_ff,     status_in;
   logic [CNT_W-1:0]     count_ff,      count_in;

   logic                 accept;
   action_type           action;
   logic [CMP_W-1:0]     pos_ext;
   logic [CMP_W-1:0]     cnt_ext;
   logic [WORD_BITS-1:0] wr_word;
   logic [WORD_BITS-1:0] read_or;
   cell_cmd_type         cmd;

   logic [WORD_BITS-1:0] cell_word [CAPACITY];
   logic [WORD_BITS-1:0] cell_tap  [CAPACITY];

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign action    = action_type'(req_action);
   assign pos_ext   = CMP_W'(req_position);
   assign cnt_ext   = CMP_W'(count_ff);
   assign wr_word   = WORD_BITS'(req_data_word);

   // gather the addressed entry from the cell taps
   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | cell_tap[i];
      end
   end

   // operation decode, status and cell command
   always_comb begin
      cmd           = '0;
      cmd.position  = req_position;
      status_in     = ST_OK;
      read_word_in  = '0;
      count_in      = count_ff;
      case (action)
         ACT_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_in = ST_RANGE;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               cmd.ins_shift = accept;
               cmd.write     = accept;
               count_in      = count_ff + 1'b1;
            end
         end
         ACT_GET: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               read_word_in = DATA_W'(read_or);
            end
         end
         ACT_UPDATE: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               cmd.write = accept;
            end
         end
         ACT_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               cmd.rem_shift = accept;
               count_in      = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_RANGE;
         end
      endcase
   end

   // output valid follows transfers on both sides
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         read_word_ff <= read_word_in;
         status_ff    <= status_in;
      end
   end

   // row of entry cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;
      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_l
         assign left_word = cell_word[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_r
         assign right_word = cell_word[g+1];
      end
      ilir_cell #(
         .INDEX     (g),
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .wr_word    (wr_word),
         .left_word  (left_word),
         .right_word (right_word),
         .value      (cell_word[g]),
         .tap        (cell_tap[g])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_word = read_word_ff;
   assign rsp_status    = status_ff;
   assign rsp_count     = COUNT_W'(count_ff);

`ifndef SYNTHESIS
   // count never passes the capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a stalled result blocks any change to the list length
   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(count_ff))
      else $error("count changed while result stalled");

   // full is only reported against a full list
   a_full_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_FULL) |-> count_ff == CNT_W'(CAPACITY))
      else $error("full status with free room");

   // a read word only comes with a good status
   a_read_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (read_word_ff != '0) |-> status_ff == ST_OK)
      else $error("read word on failed operation");
`endif

endmodule : indexed_list_insert_remove_top
`default_nettype wire

// ===== design/ilir_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilir_cell
// One list entry: compares its own index with the command position and
// holds, loads, takes its lower neighbor or takes its upper neighbor.
// ----------------------------------------------------------------------------
module ilir_cell #(
   parameter int unsigned INDEX     = 0,
   parameter int unsigned WORD_BITS = ilir_pkg::WORD_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire ilir_pkg::cell_cmd_type cmd,
   input  wire logic [WORD_BITS-1:0]   wr_word,
   input  wire logic [WORD_BITS-1:0]   left_word,
   input  wire logic [WORD_BITS-1:0]   right_word,
   output logic      [WORD_BITS-1:0]   value,
   output logic      [WORD_BITS-1:0]   tap
);
   import ilir_pkg::*;

   logic [WORD_BITS-1:0] value_ff;
   logic [WORD_BITS-1:0] value_in;
   logic                 at_pos;
   logic                 above_pos;

   // index compare against the broadcast position
   assign at_pos    = (32'(cmd.position) == INDEX);
   assign above_pos = (32'(cmd.position) <  INDEX);

   // next entry value
   always_comb begin
      value_in = value_ff;
      if (cmd.ins_shift && above_pos) begin
         value_in = left_word;
      end else if (cmd.rem_shift && (at_pos || above_pos)) begin
         value_in = right_word;
      end else if (cmd.write && at_pos) begin
         value_in = wr_word;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   // read tap, zero unless this cell is addressed
   assign tap   = at_pos ? value_ff : '0;

endmodule : ilir_cell
`default_nettype wire
